>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("smc assertion failed");
`define SMC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("smc assertion failed");
`else
`define SMC_ASSERT(label, clk, rst, prop)
`define SMC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/smc_pkg.sv
// Shared types and constants of the stack machine core
`timescale 1ns / 1ps
package smc_pkg;
   localparam int STACK_DEPTH = 1024;
   localparam int SA_BITS     = 10;
   localparam int SP_BITS     = 11;
   localparam int PC_BITS     = 9;
   localparam int WORD_BITS   = 32;
   localparam int REG_BITS    = 3;

   localparam logic [31:0] SIO_OUT  = 32'd1;
   localparam logic [31:0] SIO_IN   = 32'd2;
   localparam logic [31:0] SIO_HALT = 32'd3;

   typedef enum logic [4:0] {
      OP_LIT = 5'd1, OP_RTN = 5'd2, OP_LOD = 5'd3, OP_STO = 5'd4, OP_CAL = 5'd5,
      OP_INC = 5'd6, OP_JMP = 5'd7, OP_JPC = 5'd8, OP_SIO = 5'd9, OP_NEG = 5'd10,
      OP_ADD = 5'd11, OP_SUB = 5'd12, OP_MUL = 5'd13, OP_DIV = 5'd14, OP_ODD = 5'd15,
      OP_MOD = 5'd16, OP_EQL = 5'd17, OP_NEQ = 5'd18, OP_LSS = 5'd19, OP_LEQ = 5'd20,
      OP_GTR = 5'd21, OP_GEQ = 5'd22
   } op_type;

   typedef enum logic [1:0] {
      FLT_NONE = 2'd0, FLT_DIV0 = 2'd1, FLT_ILLEGAL = 2'd2, FLT_RANGE = 2'd3
   } fault_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quo;
      logic [31:0] rem;
   } div_rsp_type;
endpackage

>>> rtl/smc_regfile.sv
// Register file memory with per-entry valid bits, one read and one write port
`timescale 1ns / 1ps
module smc_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [2:0]  rd_addr,
   output logic [31:0] rd_data,
   input  logic        wr_en,
   input  logic [2:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem_ff [8];
   logic [7:0]  vld_ff;
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/smc_stack.sv
// Stack memory with a clearing sweep after reset
`timescale 1ns / 1ps
module smc_stack (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      busy,
   input  logic                      rd_en,
   input  logic [smc_pkg::SA_BITS-1:0] rd_addr,
   output logic [31:0]               rd_data,
   input  logic                      wr_en,
   input  logic [smc_pkg::SA_BITS-1:0] wr_addr,
   input  logic [31:0]               wr_data
);
   logic [31:0]               mem_ff [smc_pkg::STACK_DEPTH];
   logic [31:0]               rd_data_ff;
   logic [smc_pkg::SA_BITS:0] clr_ff;

   assign busy = !clr_ff[smc_pkg::SA_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (busy) begin
         clr_ff <= clr_ff + (smc_pkg::SA_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem_ff[clr_ff[smc_pkg::SA_BITS-1:0]] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/smc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module smc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  smc_pkg::div_req_type req,
   output smc_pkg::div_rsp_type rsp
);
   logic        busy_ff, done_ff, negq_ff, negr_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] quo_ff, rem_ff, den_ff;
   logic [32:0] shifted, diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff  <= req.num[31] ? (32'd0 - req.num) : req.num;
         den_ff  <= req.den[31] ? (32'd0 - req.den) : req.den;
         rem_ff  <= '0;
         negq_ff <= req.num[31] ^ req.den[31];
         negr_ff <= req.num[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = negq_ff ? (32'd0 - quo_ff) : quo_ff;
   assign rsp.rem  = negr_ff ? (32'd0 - rem_ff) : rem_ff;
endmodule

>>> rtl/stack_machine_core.sv
// Top level: instruction sequencer of the stack machine core
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | opcode, reg_index, level_or_src, m_operand, input_value
//  rsp     | out | rsp_tvalid/tready   | next_pc, base_ptr, stack_ptr, out_valid, out_value,
//          |     |                     | halted, fault
// Each item runs S_RA, S_RB, S_RR, S_EXEC and S_DONE; load, store and call also walk the static
// links (S_WALK, S_WALKW per level) and pass S_ADDR; load adds S_MEMW, call adds S_CAL1 and
// S_CAL2, return S_RET1 and S_RET2; divide/remainder wait in S_DIV (serial divider). A halted
// core goes straight to S_DONE. The register file has one read port: the three source reads
// run in turn in S_RA, S_RB and S_RR. After reset all 1024 stack words are swept to zero, with
// req_tready low. A waiting result blocks only the commit of the next item, not its acceptance.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stack_machine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[4:0], reg_index[7:5], level_or_src[17:8], m_operand[49:18],
   // input_value[81:50], zero pad
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[8:0], base_ptr[18:9], stack_ptr[29:19], out_valid[30], out_value[62:31],
   // halted[63], fault[65:64], zero pad
   output logic [71:0] rsp_tdata
);
   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_RA    = 15'b000000000000010,
      S_RB    = 15'b000000000000100,
      S_RR    = 15'b000000000001000,
      S_EXEC  = 15'b000000000010000,
      S_WALK  = 15'b000000000100000,
      S_WALKW = 15'b000000001000000,
      S_ADDR  = 15'b000000010000000,
      S_MEMW  = 15'b000000100000000,
      S_RET1  = 15'b000001000000000,
      S_RET2  = 15'b000010000000000,
      S_CAL1  = 15'b000100000000000,
      S_CAL2  = 15'b001000000000000,
      S_DIV   = 15'b010000000000000,
      S_DONE  = 15'b100000000000000
   } state_type;

   state_type          st_ff, st_in;
   smc_pkg::op_type    op_ff, op_in;
   logic [2:0]         ri_ff, ri_in;
   logic [9:0]         lv_ff, lv_in;
   logic [31:0]        m_ff, m_in, iv_ff, iv_in;
   logic [31:0]        a_ff, a_in, b_ff, b_in;
   logic [8:0]         pc_ff, pc_in, npc_ff, npc_in;
   logic [9:0]         bp_ff, bp_in, nbp_ff, nbp_in;
   logic [10:0]        sp_ff, sp_in, nsp_ff, nsp_in;
   logic               halt_ff, halt_in, hlt_ff, hlt_in;
   logic [9:0]         cnt_ff, cnt_in;
   logic [31:0]        base_ff, base_in;
   logic               wb_ff, wb_in, ov_ff, ov_in;
   logic [31:0]        wbv_ff, wbv_in, oval_ff, oval_in;
   smc_pkg::fault_type flt_ff, flt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;

   logic               rf_rd_en, rf_we;
   logic [2:0]         rf_rd_addr;
   logic [31:0]        rf_rd;
   logic               stk_busy, stk_rd_en, stk_we;
   logic [9:0]         stk_rd_addr, stk_wr_addr;
   logic [31:0]        stk_rd, stk_wr_data;
   smc_pkg::div_req_type div_req;
   smc_pkg::div_rsp_type div_rsp;

   logic               go, ok;
   logic [33:0]        m_ext, sp_d, off_d;
   logic [8:0]         fin_pc;
   logic [9:0]         fin_bp;
   logic [10:0]        fin_sp;
   logic               fin_halt;

   assign req_tready = (st_ff == S_IDLE) && !stk_busy;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign go         = !rsp_valid_ff || rsp_tready;
   assign ok         = (flt_ff == smc_pkg::FLT_NONE);
   assign m_ext      = {{2{m_ff[31]}}, m_ff};
   assign sp_d       = {23'd0, sp_ff} - m_ext;
   assign off_d      = {2'b00, base_ff} - m_ext;
   assign fin_pc     = ok ? npc_ff : pc_ff;
   assign fin_bp     = ok ? nbp_ff : bp_ff;
   assign fin_sp     = ok ? nsp_ff : sp_ff;
   assign fin_halt   = halt_ff ||
                       (ok && (hlt_ff || (fin_pc == '0 && fin_bp == '0 && fin_sp == '0)));
   assign rf_we      = (st_ff == S_DONE) && go && wb_ff && ok;

   always_comb begin
      st_in = st_ff;   op_in = op_ff;   ri_in = ri_ff;   lv_in = lv_ff;
      m_in = m_ff;     iv_in = iv_ff;   a_in = a_ff;     b_in = b_ff;
      pc_in = pc_ff;   bp_in = bp_ff;   sp_in = sp_ff;   halt_in = halt_ff;
      npc_in = npc_ff; nbp_in = nbp_ff; nsp_in = nsp_ff; hlt_in = hlt_ff;
      cnt_in = cnt_ff; base_in = base_ff;
      wb_in = wb_ff;   wbv_in = wbv_ff; ov_in = ov_ff;   oval_in = oval_ff;
      flt_in = flt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rf_rd_en = 1'b0; rf_rd_addr = lv_ff[2:0];
      stk_rd_en = 1'b0; stk_rd_addr = bp_ff - 10'd1;
      stk_we = 1'b0; stk_wr_addr = off_d[9:0]; stk_wr_data = rf_rd;
      div_req.start = 1'b0; div_req.num = a_ff; div_req.den = b_ff;

      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid && !stk_busy) begin
               op_in  = smc_pkg::op_type'(req_tdata[4:0]);
               ri_in  = req_tdata[7:5];
               lv_in  = req_tdata[17:8];
               m_in   = req_tdata[49:18];
               iv_in  = req_tdata[81:50];
               npc_in = pc_ff; nbp_in = bp_ff; nsp_in = sp_ff;
               hlt_in = 1'b0; wb_in = 1'b0; ov_in = 1'b0; oval_in = '0;
               flt_in = smc_pkg::FLT_NONE;
               st_in  = halt_ff ? S_DONE : S_RA;
            end
         end
         S_RA: begin
            rf_rd_en = 1'b1; rf_rd_addr = lv_ff[2:0]; st_in = S_RB;
         end
         S_RB: begin
            a_in = rf_rd; rf_rd_en = 1'b1; rf_rd_addr = m_ff[2:0]; st_in = S_RR;
         end
         S_RR: begin
            b_in = rf_rd; rf_rd_en = 1'b1; rf_rd_addr = ri_ff; st_in = S_EXEC;
         end
         S_EXEC: begin
            npc_in = pc_ff + 9'd1;
            st_in  = S_DONE;
            unique case (op_ff)
               smc_pkg::OP_LIT: begin wb_in = 1'b1; wbv_in = m_ff; end
               smc_pkg::OP_RTN: begin
                  if (bp_ff < 10'd2) begin
                     flt_in = smc_pkg::FLT_RANGE;
                  end else begin
                     stk_rd_en = 1'b1; stk_rd_addr = bp_ff - 10'd1; st_in = S_RET1;
                  end
               end
               smc_pkg::OP_LOD, smc_pkg::OP_STO, smc_pkg::OP_CAL: begin
                  base_in = {22'd0, bp_ff}; cnt_in = lv_ff; st_in = S_WALK;
               end
               smc_pkg::OP_INC: begin
                  if (sp_d[33] || sp_d[32:11] != '0 || (sp_d[10] && sp_d[9:0] != '0)) begin
                     flt_in = smc_pkg::FLT_RANGE;
                  end else begin
                     nsp_in = sp_d[10:0];
                  end
               end
               smc_pkg::OP_JMP: npc_in = m_ff[8:0];
               smc_pkg::OP_JPC: if (rf_rd == '0) npc_in = m_ff[8:0];
               smc_pkg::OP_SIO: begin
                  if (m_ff == smc_pkg::SIO_OUT) begin
                     ov_in = 1'b1; oval_in = rf_rd;
                  end else if (m_ff == smc_pkg::SIO_IN) begin
                     wb_in = 1'b1; wbv_in = iv_ff;
                  end else if (m_ff == smc_pkg::SIO_HALT) begin
                     hlt_in = 1'b1;
                  end
               end
               smc_pkg::OP_NEG: begin wb_in = 1'b1; wbv_in = 32'd0 - rf_rd; end
               smc_pkg::OP_ADD: begin wb_in = 1'b1; wbv_in = a_ff + b_ff; end
               smc_pkg::OP_SUB: begin wb_in = 1'b1; wbv_in = a_ff - b_ff; end
               smc_pkg::OP_MUL: begin wb_in = 1'b1; wbv_in = a_ff * b_ff; end
               smc_pkg::OP_DIV, smc_pkg::OP_MOD: begin
                  if (b_ff == '0) begin
                     flt_in = smc_pkg::FLT_DIV0;
                  end else begin
                     div_req.start = 1'b1; st_in = S_DIV;
                  end
               end
               smc_pkg::OP_ODD: begin
                  wb_in  = 1'b1;
                  wbv_in = !rf_rd[0] ? 32'd0 : (rf_rd[31] ? '1 : 32'd1);
               end
               smc_pkg::OP_EQL: begin wb_in = 1'b1; wbv_in = {31'd0, a_ff == b_ff}; end
               smc_pkg::OP_NEQ: begin wb_in = 1'b1; wbv_in = {31'd0, a_ff != b_ff}; end
               smc_pkg::OP_LSS: begin
                  wb_in = 1'b1; wbv_in = {31'd0, $signed(a_ff) < $signed(b_ff)};
               end
               smc_pkg::OP_LEQ: begin
                  wb_in = 1'b1; wbv_in = {31'd0, $signed(a_ff) <= $signed(b_ff)};
               end
               smc_pkg::OP_GTR: begin
                  wb_in = 1'b1; wbv_in = {31'd0, $signed(a_ff) > $signed(b_ff)};
               end
               smc_pkg::OP_GEQ: begin
                  wb_in = 1'b1; wbv_in = {31'd0, $signed(a_ff) >= $signed(b_ff)};
               end
               default: flt_in = smc_pkg::FLT_ILLEGAL;
            endcase
         end
         S_WALK: begin
            if (cnt_ff == '0) begin
               st_in = S_ADDR;
            end else if (base_ff[31:10] != '0) begin
               flt_in = smc_pkg::FLT_RANGE; st_in = S_DONE;
            end else begin
               stk_rd_en = 1'b1; stk_rd_addr = base_ff[9:0];
               cnt_in = cnt_ff - 10'd1; st_in = S_WALKW;
            end
         end
         S_WALKW: begin
            base_in = stk_rd; st_in = S_WALK;
         end
         S_ADDR: begin
            st_in = S_DONE;
            if (base_ff[31:10] != '0) begin
               flt_in = smc_pkg::FLT_RANGE;
            end else if (op_ff == smc_pkg::OP_CAL) begin
               if (sp_ff < 11'd3) begin
                  flt_in = smc_pkg::FLT_RANGE;
               end else begin
                  stk_we = 1'b1; stk_wr_addr = 10'(sp_ff - 11'd1); stk_wr_data = base_ff;
                  nbp_in = 10'(sp_ff - 11'd1); npc_in = m_ff[8:0];
                  st_in = S_CAL1;
               end
            end else if (off_d[33:10] != '0) begin
               flt_in = smc_pkg::FLT_RANGE;
            end else if (op_ff == smc_pkg::OP_LOD) begin
               stk_rd_en = 1'b1; stk_rd_addr = off_d[9:0]; st_in = S_MEMW;
            end else begin
               stk_we = 1'b1; stk_wr_addr = off_d[9:0]; stk_wr_data = rf_rd;
            end
         end
         S_MEMW: begin
            wb_in = 1'b1; wbv_in = stk_rd; st_in = S_DONE;
         end
         S_RET1: begin
            if (stk_rd[31:10] != '0) begin
               flt_in = smc_pkg::FLT_RANGE; st_in = S_DONE;
            end else begin
               nbp_in = stk_rd[9:0]; nsp_in = {1'b0, bp_ff} + 11'd1;
               stk_rd_en = 1'b1; stk_rd_addr = bp_ff - 10'd2; st_in = S_RET2;
            end
         end
         S_RET2: begin
            npc_in = stk_rd[8:0]; st_in = S_DONE;
         end
         S_CAL1: begin
            stk_we = 1'b1; stk_wr_addr = 10'(sp_ff - 11'd2); stk_wr_data = {22'd0, bp_ff};
            st_in = S_CAL2;
         end
         S_CAL2: begin
            stk_we = 1'b1; stk_wr_addr = 10'(sp_ff - 11'd3);
            stk_wr_data = {23'd0, pc_ff + 9'd1};
            st_in = S_DONE;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               wb_in  = 1'b1;
               wbv_in = (op_ff == smc_pkg::OP_DIV) ? div_rsp.quo : div_rsp.rem;
               st_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (go) begin
               pc_in = fin_pc; bp_in = fin_bp; sp_in = fin_sp; halt_in = fin_halt;
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'd0, flt_ff, fin_halt, (ok && ov_ff) ? oval_ff : 32'd0,
                              ok && ov_ff, fin_sp, fin_bp, fin_pc};
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pc_ff        <= '0;
         bp_ff        <= 10'(smc_pkg::STACK_DEPTH - 1);
         sp_ff        <= 11'(smc_pkg::STACK_DEPTH);
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pc_ff        <= pc_in;
         bp_ff        <= bp_in;
         sp_ff        <= sp_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;   ri_ff <= ri_in;   lv_ff <= lv_in;   m_ff <= m_in;
      iv_ff <= iv_in;   a_ff <= a_in;     b_ff <= b_in;
      npc_ff <= npc_in; nbp_ff <= nbp_in; nsp_ff <= nsp_in; hlt_ff <= hlt_in;
      cnt_ff <= cnt_in; base_ff <= base_in;
      wb_ff <= wb_in;   wbv_ff <= wbv_in; ov_ff <= ov_in;   oval_ff <= oval_in;
      flt_ff <= flt_in; rsp_data_ff <= rsp_data_in;
   end

   smc_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rf_rd_en),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd),
      .wr_en   (rf_we),
      .wr_addr (ri_ff),
      .wr_data (wbv_ff)
   );

   smc_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .busy    (stk_busy),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data)
   );

   smc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   `SMC_ASSERT(a_clear_blocks_req, clock, reset, stk_busy |-> !req_tready)
   `SMC_ASSERT(a_halt_sticky, clock, reset, halt_ff |=> halt_ff)
   `SMC_ASSERT(a_div_in_div_state, clock, reset, div_rsp.busy |-> (st_ff == S_DIV))
   `SMC_ASSERT(a_rf_write_clean, clock, reset, rf_we |-> (flt_ff == smc_pkg::FLT_NONE))
   `SMC_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_tvalid)
endmodule
